FILE: sv/serial_frame_receiver_drive_decode_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the serial frame receiver
// Shared immediate-style wrappers around clocked concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef SERIAL_FRAME_RECEIVER_DRIVE_DECODE_ASSERT_SVH
`define SERIAL_FRAME_RECEIVER_DRIVE_DECODE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SFR_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SFR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Types and constants shared by the serial frame receiver modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned POS_W   = 9;
   localparam int unsigned DRIVE_W = 4;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 9;

   localparam logic [BYTE_W-1:0] HEAD_FIRST    = 8'hAB;
   localparam logic [BYTE_W-1:0] HEAD_SECOND   = 8'hBA;
   localparam logic [POS_W-1:0]  PAYLOAD_START = 9'd5;
   localparam logic [POS_W-1:0]  LENGTH_POS    = 9'd4;
   localparam logic [POS_W-1:0]  MAX_POS       = 9'd260;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_COMMAND_POSITION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CONTROL_POSITION = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CONTROL_CODE     = 2'd2;

   localparam logic [POS_W-1:0]  RST_COMMAND_POSITION = 9'd2;
   localparam logic [POS_W-1:0]  RST_CONTROL_POSITION = 9'd8;
   localparam logic [BYTE_W-1:0] RST_CONTROL_CODE     = 8'd1;

   typedef struct packed {
      logic [POS_W-1:0]  command_position;
      logic [POS_W-1:0]  control_position;
      logic [BYTE_W-1:0] control_code;
   } cfg_type;

   typedef struct packed {
      logic               frame_done;
      logic               frame_ok;
      logic [DRIVE_W-1:0] drive_bits;
      logic               drive_updated;
      logic               reply_request;
   } result_type;

   typedef struct packed {
      logic [POS_W-1:0]   frame_position;
      logic [DRIVE_W-1:0] drive_state;
   } parse_status_type;

endpackage

`default_nettype wire

FILE: sv/sfr_if.sv
// ----------------------------------------------------------------------------
// sfr_req_if / sfr_rsp_if
// Valid/ready channels carrying received bytes in and frame results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr_rsp_if;
   logic       valid;
   logic       ready;
   logic       frame_done;
   logic       frame_ok;
   logic [3:0] drive_bits;
   logic       drive_updated;
   logic       reply_request;

   modport source (output valid, output frame_done, output frame_ok,
                   output drive_bits, output drive_updated,
                   output reply_request, input ready);
   modport sink   (input valid, input frame_done, input frame_ok,
                   input drive_bits, input drive_updated,
                   input reply_request, output ready);
endinterface

`default_nettype wire

FILE: sv/sfr_csr.sv
// ----------------------------------------------------------------------------
// sfr_csr
// Configuration registers written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [sfr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sfr_pkg::CSR_DATA_W-1:0] csr_wdata,
   output sfr_pkg::cfg_type                    cfg
);
   import sfr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         if (csr_index == CSR_COMMAND_POSITION) begin
            cfg_in.command_position = csr_wdata[POS_W-1:0];
         end else if (csr_index == CSR_CONTROL_POSITION) begin
            cfg_in.control_position = csr_wdata[POS_W-1:0];
         end else if (csr_index == CSR_CONTROL_CODE) begin
            cfg_in.control_code = csr_wdata[BYTE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.command_position <= RST_COMMAND_POSITION;
         cfg_ff.control_position <= RST_CONTROL_POSITION;
         cfg_ff.control_code     <= RST_CONTROL_CODE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: sv/sfr_parse.sv
// ----------------------------------------------------------------------------
// sfr_parse
// Frame parser state: position, length, running sum, captures and drive.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_parse (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       step,
   input  wire logic [sfr_pkg::BYTE_W-1:0] rx_byte,
   input  sfr_pkg::cfg_type                cfg,
   output sfr_pkg::result_type             result,
   output sfr_pkg::parse_status_type       status
);
   import sfr_pkg::*;

   logic [POS_W-1:0]   pos_ff,   pos_in;
   logic [BYTE_W-1:0]  len_ff,   len_in;
   logic [BYTE_W-1:0]  sum_ff,   sum_in;
   logic [BYTE_W-1:0]  cmd_ff,   cmd_in;
   logic [BYTE_W-1:0]  ctrl_ff,  ctrl_in;
   logic [DRIVE_W-1:0] drive_ff, drive_in;

   logic [POS_W-1:0]  frame_end;
   logic [BYTE_W-1:0] sum_add;
   logic              done;
   logic              ok;
   logic              upd;

   assign frame_end = {1'b0, len_ff} + PAYLOAD_START;
   assign sum_add   = sum_ff + rx_byte;

   always_comb begin
      // Captures take effect before the drive decision of the same byte.
      cmd_in  = (pos_ff == cfg.command_position) ? rx_byte : cmd_ff;
      ctrl_in = (pos_ff == cfg.control_position) ? rx_byte : ctrl_ff;
      len_in  = len_ff;
      sum_in  = sum_add;
      pos_in  = pos_ff + 9'd1;
      done    = 1'b0;
      ok      = 1'b0;

      if (pos_ff == '0) begin
         if (rx_byte == HEAD_FIRST) begin
            sum_in = rx_byte;
         end else begin
            sum_in = '0;
            pos_in = '0;
         end
      end else if (pos_ff == 9'd1) begin
         if (rx_byte != HEAD_SECOND) begin
            sum_in = '0;
            pos_in = '0;
         end
      end else if (pos_ff < PAYLOAD_START) begin
         if (pos_ff == LENGTH_POS) begin
            len_in = rx_byte;
         end
      end else if (pos_ff >= frame_end) begin
         done   = 1'b1;
         ok     = (rx_byte == sum_ff);
         sum_in = '0;
         pos_in = '0;
      end

      upd      = ok && (cmd_in == cfg.control_code);
      drive_in = upd ? ctrl_in[DRIVE_W-1:0] : drive_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         len_ff   <= '0;
         sum_ff   <= '0;
         cmd_ff   <= '0;
         ctrl_ff  <= '0;
         drive_ff <= '0;
      end else if (step) begin
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         sum_ff   <= sum_in;
         cmd_ff   <= cmd_in;
         ctrl_ff  <= ctrl_in;
         drive_ff <= drive_in;
      end
   end

   always_comb begin
      result.frame_done    = done;
      result.frame_ok      = ok;
      result.drive_bits    = drive_in;
      result.drive_updated = upd;
      result.reply_request = upd;
   end

   assign status.frame_position = pos_ff;
   assign status.drive_state    = drive_ff;

endmodule

`default_nettype wire

FILE: sv/serial_frame_receiver_drive_decode.sv
// ----------------------------------------------------------------------------
// serial_frame_receiver_drive_decode
// Frame receiver with additive checksum and held drive-control outputs.
// ----------------------------------------------------------------------------
// Usage: received bytes enter on the req channel, one byte per transaction.
// For every byte the block returns exactly one result transaction on the
// rsp channel: frame_done marks the checksum byte of a frame, frame_ok a
// matching checksum, drive_bits the held drive state after this byte, and
// drive_updated together with reply_request flag a frame that loaded them.
// A byte accepted on req sits in the input register, is decoded into the
// result register once that register is free, and is offered on rsp from
// then on. Throughput is one byte per cycle while rsp does not stall; the
// rate is set by the single pass of compare, add and position update
// between the two registers. The csr port writes command_position (index
// 0), control_position (index 1) and control_code (index 2) and is meant
// to be used while no transaction is in flight.
// Reset clears both pipeline stages, restarts the header search with a zero
// sum, turns all drives off and loads the register defaults 2, 8 and 1.
// When the receiver stalls, the result is held and the input register still
// takes one more byte; req.ready drops only when both stages are full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "serial_frame_receiver_drive_decode_assert.svh"

module serial_frame_receiver_drive_decode (
   input  wire logic                           clock,
   input  wire logic                           reset,
   sfr_req_if.sink                             req,
   sfr_rsp_if.source                           rsp,
   input  wire logic                           csr_we,
   input  wire logic [sfr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sfr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import sfr_pkg::*;

   cfg_type          cfg;
   result_type       result;
   parse_status_type status;

   // Input register stage.
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff,  in_byte_in;

   // Result register stage.
   logic       out_valid_ff, out_valid_in;
   result_type out_ff,       out_in;

   logic out_free;
   logic step;
   logic req_take;

   // The result register can load when it is empty or being drained.
   assign out_free  = !out_valid_ff || rsp.ready;
   assign step      = in_valid_ff && out_free;
   assign req.ready = !in_valid_ff || out_free;
   assign req_take  = req.valid && req.ready;

   sfr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sfr_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .cfg     (cfg),
      .result  (result),
      .status  (status)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req.rx_byte;
      end else if (step) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (step) begin
         out_valid_in = 1'b1;
         out_in       = result;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.frame_done    = out_ff.frame_done;
   assign rsp.frame_ok      = out_ff.frame_ok;
   assign rsp.drive_bits    = out_ff.drive_bits;
   assign rsp.drive_updated = out_ff.drive_updated;
   assign rsp.reply_request = out_ff.reply_request;

   // A drive load needs a frame that finished with a good checksum.
   `SFR_ASSERT_NOW(a_upd_needs_ok, rsp.valid && rsp.drive_updated,
      rsp.frame_ok && rsp.frame_done && rsp.reply_request,
      "drive update without a completed good frame")

   // The frame position never runs past the longest possible frame.
   `SFR_ASSERT_NOW(a_pos_bound, 1'b1, status.frame_position <= MAX_POS,
      "frame position beyond the last checksum index")

   // A byte waiting in the input register is kept until it is decoded.
   `SFR_ASSERT_NEXT(a_in_hold, in_valid_ff && !out_free,
      in_valid_ff && $stable(in_byte_ff),
      "pending input byte lost while the result stage was full")

   // The held drive state moves only when a byte is decoded.
   `SFR_ASSERT_NEXT(a_drive_hold, !step, $stable(status.drive_state),
      "drive state changed without a decoded byte")

endmodule

`default_nettype wire
